### src/pbwa_pkg.sv
`timescale 1ns / 1ps

package pbwa_pkg;

    localparam int WINDOW_COUNT = 3;
    localparam int ADDR_W       = 64;
    localparam int WORD_W       = 32;
    localparam int IN_TDATA_W   = 128;
    localparam int OUT_TDATA_W  = 200;
    localparam int CFG_IDX_W    = 3;

    localparam logic [1:0] KIND_IO    = 2'd0;
    localparam logic [1:0] KIND_MEM32 = 2'd1;
    localparam logic [1:0] KIND_MEM64 = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // memory type field of a memory BAR, low word bits [2:1]
    localparam logic [1:0] MEM_TYPE_32 = 2'b00;
    localparam logic [1:0] MEM_TYPE_64 = 2'b10;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT = 3'd6;

    localparam logic [ADDR_W-1:0] FLAG_MASK_IO  = 64'h3;
    localparam logic [ADDR_W-1:0] FLAG_MASK_MEM = 64'hf;
    localparam logic [WORD_W-1:0] UPPER_FILL    = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]        kind;
        logic              req;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] cur_addr;
    } bar_dec_t;

endpackage

### src/pbwa_decode.sv
`timescale 1ns / 1ps

module pbwa_decode
    import pbwa_pkg::*;
(
    input  logic [IN_TDATA_W-1:0] tdata,
    output bar_dec_t              dec
);

    logic [WORD_W-1:0] lo_val;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_val;
    logic [WORD_W-1:0] hi_mask;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] raw_addr;
    logic [ADDR_W-1:0] raw_mask;
    logic [ADDR_W-1:0] masked;

    assign lo_val  = tdata[31:0];
    assign lo_mask = tdata[63:32];
    assign hi_val  = tdata[95:64];
    assign hi_mask = tdata[127:96];

    always_comb
    begin
        if (lo_val[0])
        begin
            kind = KIND_IO;
        end
        else
        begin
            case (lo_val[2:1])
                MEM_TYPE_32: kind = KIND_MEM32;
                MEM_TYPE_64: kind = KIND_MEM64;
                default:     kind = KIND_OTHER;
            endcase
        end
    end

    always_comb
    begin
        if (kind == KIND_MEM64)
        begin
            raw_addr = {hi_val, lo_val};
            raw_mask = {hi_mask, lo_mask};
        end
        else
        begin
            raw_addr = {{WORD_W{1'b0}}, lo_val};
            // fill the upper half of a nonzero 32-bit mask with ones
            raw_mask = (lo_mask != '0) ? {UPPER_FILL, lo_mask} : {ADDR_W{1'b0}};
        end
    end

    assign masked = raw_mask & ~FLAG_MASK_MEM;

    assign dec.kind     = kind;
    assign dec.mask     = masked;
    assign dec.size     = ~masked + 64'd1;
    assign dec.req      = (kind != KIND_OTHER) && (masked != '0);
    assign dec.cur_addr = raw_addr & ~((kind == KIND_IO) ? FLAG_MASK_IO : FLAG_MASK_MEM);

endmodule

### src/pci_bar_window_allocator.sv
`timescale 1ns / 1ps
// An accepted beat is registered in s1_reg, then its result in out_data_reg.
// Throughput: one beat per cycle unless m_axis stalls; on a grant with no config
// write the kind's free pointer moves with the result load, so beats of one kind chain.
// Reset (rst_n low, asynchronous): both pipeline stages empty, window bases and
// sizes 0, every free pointer 1.

module pci_bar_window_allocator
    import pbwa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] probe_low_value, [63:32] probe_low_mask,
    // [95:64] probe_high_value, [127:96] probe_high_mask
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [63:0] region_size, [127:64] current_address,
    // [191:128] assigned_address, [192] assign_done, [193] out_of_window,
    // [194] uses_two_slots, [199:195] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] bar_kind
    output logic [1:0]             m_axis_tuser,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    bar_dec_t          dec;
    bar_dec_t          s1_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [1:0]        out_kind_reg;

    logic [ADDR_W-1:0] base_reg [WINDOW_COUNT];
    logic [ADDR_W-1:0] len_reg  [WINDOW_COUNT];
    logic [ADDR_W-1:0] free_reg [WINDOW_COUNT];

    logic              out_load;
    logic              s1_adv;
    logic [ADDR_W-1:0] sel_free;
    logic [ADDR_W-1:0] sel_base;
    logic [ADDR_W-1:0] sel_len;
    logic [ADDR_W-1:0] rounded;
    logic [ADDR_W-1:0] alloc_end;
    logic              fail;
    logic              grant;
    logic [1:0]        cfg_win;

    pbwa_decode u_decode
    (
        .tdata (s_axis_tdata),
        .dec   (dec)
    );

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_load;
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    always_comb
    begin
        case (s1_reg.kind)
            KIND_IO:
            begin
                sel_free = free_reg[0];
                sel_base = base_reg[0];
                sel_len  = len_reg[0];
            end
            KIND_MEM32:
            begin
                sel_free = free_reg[1];
                sel_base = base_reg[1];
                sel_len  = len_reg[1];
            end
            KIND_MEM64:
            begin
                sel_free = free_reg[2];
                sel_base = base_reg[2];
                sel_len  = len_reg[2];
            end
            default:
            begin
                sel_free = '0;
                sel_base = '0;
                sel_len  = '0;
            end
        endcase
    end

    // size - 1 is the inverted mask and its complement is the mask itself
    assign rounded   = (sel_free + ~s1_reg.mask) & s1_reg.mask;
    assign alloc_end = rounded + s1_reg.size;
    assign fail      = s1_reg.req && ((alloc_end - sel_base) > sel_len);
    assign grant     = s1_reg.req && !fail;

    always_comb
    begin
        out_data_next          = '0;
        out_data_next[63:0]    = s1_reg.size;
        out_data_next[127:64]  = s1_reg.cur_addr;
        out_data_next[191:128] = grant ? rounded : {ADDR_W{1'b0}};
        out_data_next[192]     = s1_reg.req;
        out_data_next[193]     = fail;
        out_data_next[194]     = (s1_reg.kind == KIND_MEM64);
    end

    assign cfg_win = cfg_index[2:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            s1_reg <= dec;
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= s1_reg.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_COUNT; i++)
            begin
                base_reg[i] <= '0;
                len_reg[i]  <= '0;
                free_reg[i] <= 64'd1;
            end
        end
        else if (cfg_we && (cfg_index < CFG_REG_COUNT))
        begin
            if (!cfg_index[0])
            begin
                base_reg[cfg_win] <= cfg_data;
                free_reg[cfg_win] <= (cfg_data != '0) ? cfg_data : 64'd1;
            end
            else
            begin
                len_reg[cfg_win] <= cfg_data;
            end
        end
        else if (s1_adv && grant)
        begin
            // advance the kind's pointer past the new region
            free_reg[s1_reg.kind] <= alloc_end;
        end
    end

endmodule

### src/pbwa_checker.sv
`timescale 1ns / 1ps

module pbwa_checker
    import pbwa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    logic [1:0]        kind;
    logic [ADDR_W-1:0] assigned;
    logic              done;
    logic              oow;
    logic              two_slots;

    assign kind      = m_axis_tuser;
    assign assigned  = m_axis_tdata[191:128];
    assign done      = m_axis_tdata[192];
    assign oow       = m_axis_tdata[193];
    assign two_slots = m_axis_tdata[194];

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_no_alloc_other: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (kind == KIND_OTHER) |-> !done && !oow && (assigned == '0))
        else $error("allocation reported for an unknown BAR kind");

    a_fail_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && oow |-> done && (assigned == '0))
        else $error("overrun without a request or with an address");

    a_two_slots: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (two_slots == (kind == KIND_MEM64)))
        else $error("two-slot flag disagrees with kind");

endmodule

bind pci_bar_window_allocator pbwa_checker u_pbwa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
